[src/mcpid_pkg.sv]
`timescale 1ns / 1ps

package mcpid_pkg;

  localparam int TRIG_TABLE_BITS_DEF = 10;
  localparam int FRAC_BITS_DEF       = 16;

  localparam int NUM_WHEELS = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_LIMIT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_LIMIT = 3'd4;

  // PID term being multiplied
  localparam logic [1:0] TERM_P = 2'd0;
  localparam logic [1:0] TERM_I = 2'd1;
  localparam logic [1:0] TERM_D = 2'd2;

  // preparation steps before the PID loop
  localparam logic [2:0] STEP_RECIP  = 3'd0;
  localparam logic [2:0] STEP_CORR   = 3'd1;
  localparam logic [2:0] STEP_ROM    = 3'd2;
  localparam logic [2:0] STEP_MUL_A  = 3'd3;
  localparam logic [2:0] STEP_MUL_B  = 3'd4;
  localparam logic [2:0] STEP_MIX    = 3'd5;
  localparam logic [2:0] STEP_ERR    = 3'd6;
  localparam logic [2:0] STEP_COMMIT = 3'd7;

  typedef struct packed {
    logic       load;
    logic       prep_en;
    logic [2:0] prep_step;
    logic       pid_en;
    logic [1:0] pid_wheel;
    logic [1:0] pid_term;
    logic       pid_hi;
    logic       out_load;
  } ctrl_cmd_t;

endpackage

[src/mecanum_chassis_pid_top.sv]
`timescale 1ns / 1ps

// Mecanum chassis speed controller, one word per control tick.
// Input channel (in_valid_i / in_ready_o) carries stick targets, raw yaw,
// spin command and four measured wheel speeds. Output channel
// (out_valid_o / out_ready_i) carries the four clamped wheel drives.
// Config port: cfg_we_i writes cfg_data_i into register cfg_index_i
// (0 gain_p, 1 gain_i, 2 gain_d, 3 output_limit, 4 integral_limit);
// other indexes are ignored. Write only while the block is idle.
// Sequence from accept to out_valid_o: prep steps (yaw and speed reciprocal
// scaling and correction, sine table, rotation, mecanum mixing with spin ramp,
// wheel error and integral commit), the one shared gain multiplier (4 wheels x
// 3 terms x 2 operand halves), a drain state and an output load state.
// The next word is accepted only back in idle, after this result is loaded.
// A new word is accepted while the previous result still waits; if the
// receiver stalls, the next result holds inside until the output frees.
// Reset: spin rate, error history and integrals clear, gains go to 0,
// output limit to 6500 and integral limit to 9450.
module mecanum_chassis_pid_top #(
  parameter int TrigTableBits = mcpid_pkg::TRIG_TABLE_BITS_DEF,
  parameter int FracBits      = mcpid_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic signed [11:0]               target_y_i,
  input  logic signed [11:0]               target_x_i,
  input  logic [12:0]                      yaw_angle_i,
  input  logic [1:0]                       spin_cmd_i,
  input  logic signed [15:0]               wheel1_speed_i,
  input  logic signed [15:0]               wheel2_speed_i,
  input  logic signed [15:0]               wheel3_speed_i,
  input  logic signed [15:0]               wheel4_speed_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [14:0]               wheel1_drive_o,
  output logic signed [14:0]               wheel2_drive_o,
  output logic signed [14:0]               wheel3_drive_o,
  output logic signed [14:0]               wheel4_drive_o,
  input  logic                             cfg_we_i,
  input  logic [mcpid_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [mcpid_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import mcpid_pkg::*;

  ctrl_cmd_t cmd;

  mcpid_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  mcpid_datapath #(
    .TrigTableBits (TrigTableBits),
    .FracBits      (FracBits)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .target_y_i     (target_y_i),
    .target_x_i     (target_x_i),
    .yaw_angle_i    (yaw_angle_i),
    .spin_cmd_i     (spin_cmd_i),
    .wheel1_speed_i (wheel1_speed_i),
    .wheel2_speed_i (wheel2_speed_i),
    .wheel3_speed_i (wheel3_speed_i),
    .wheel4_speed_i (wheel4_speed_i),
    .wheel1_drive_o (wheel1_drive_o),
    .wheel2_drive_o (wheel2_drive_o),
    .wheel3_drive_o (wheel3_drive_o),
    .wheel4_drive_o (wheel4_drive_o)
  );

endmodule

[src/mcpid_ctrl.sv]
`timescale 1ns / 1ps

module mcpid_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output mcpid_pkg::ctrl_cmd_t cmd_o
);
  import mcpid_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PREP  = 3'd1;
  localparam logic [2:0] ST_PID   = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  localparam logic [1:0] LAST_WHEEL = 2'(NUM_WHEELS - 1);

  logic [2:0] state_q, state_d;
  logic [2:0] step_q, step_d;
  logic [1:0] wheel_q, wheel_d;
  logic [1:0] term_q, term_d;
  logic       hi_q, hi_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    wheel_d     = wheel_q;
    term_d      = term_q;
    hi_d        = hi_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    cmd_o.prep_step = step_q;
    cmd_o.pid_wheel = wheel_q;
    cmd_o.pid_term  = term_q;
    cmd_o.pid_hi    = hi_q;
    in_ready_o  = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          step_d     = STEP_RECIP;
          state_d    = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd_o.prep_en = 1'b1;
        if (step_q == STEP_COMMIT) begin
          wheel_d = '0;
          term_d  = TERM_P;
          hi_d    = 1'b0;
          state_d = ST_PID;
        end else begin
          step_d = step_q + 3'd1;
        end
      end
      ST_PID: begin
        cmd_o.pid_en = 1'b1;
        if (!hi_q) begin
          hi_d = 1'b1;
        end else begin
          hi_d = 1'b0;
          if (term_q != TERM_D) begin
            term_d = term_q + 2'd1;
          end else begin
            term_d = TERM_P;
            if (wheel_q == LAST_WHEEL) begin
              state_d = ST_DRAIN;
            end else begin
              wheel_d = wheel_q + 2'd1;
            end
          end
        end
      end
      ST_DRAIN: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        // output word register must be free or emptying this cycle
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      wheel_q     <= '0;
      term_q      <= TERM_P;
      hi_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      wheel_q     <= wheel_d;
      term_q      <= term_d;
      hi_q        <= hi_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef NO_ASSERTIONS
  a_load_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over a pending word");

  a_accept_prep : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_PREP && step_q == STEP_RECIP))
    else $error("accept did not start preparation");

  a_term_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PID) |-> (term_q == TERM_P || term_q == TERM_I || term_q == TERM_D))
    else $error("bad PID term");

  a_rose_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q) == ST_DONE))
    else $error("result raised outside done");

  a_pid_after_prep : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PREP && step_q == STEP_COMMIT) |=>
      (state_q == ST_PID && wheel_q == 2'd0 && term_q == TERM_P && !hi_q))
    else $error("PID loop did not start clean");
`endif

endmodule

[src/mcpid_datapath.sv]
`timescale 1ns / 1ps

module mcpid_datapath #(
  parameter int TrigTableBits = mcpid_pkg::TRIG_TABLE_BITS_DEF,
  parameter int FracBits      = mcpid_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  mcpid_pkg::ctrl_cmd_t                 cmd_i,
  input  logic                                 cfg_we_i,
  input  logic [mcpid_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [mcpid_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic signed [11:0]                   target_y_i,
  input  logic signed [11:0]                   target_x_i,
  input  logic [12:0]                          yaw_angle_i,
  input  logic [1:0]                           spin_cmd_i,
  input  logic signed [15:0]                   wheel1_speed_i,
  input  logic signed [15:0]                   wheel2_speed_i,
  input  logic signed [15:0]                   wheel3_speed_i,
  input  logic signed [15:0]                   wheel4_speed_i,
  output logic signed [14:0]                   wheel1_drive_o,
  output logic signed [14:0]                   wheel2_drive_o,
  output logic signed [14:0]                   wheel3_drive_o,
  output logic signed [14:0]                   wheel4_drive_o
);
  import mcpid_pkg::*;

  localparam int T    = TrigTableBits;
  localparam int F    = FracBits;
  localparam int QTR  = (1 << T) / 4;
  localparam int YAW_TURN = 16471;
  localparam int YAW_HALF = YAW_TURN / 2;
  // yaw index: round(yaw * 2^T / YAW_TURN) by reciprocal plus one correction
  localparam int NYW  = T + 14;
  localparam longint unsigned RY = (64'd1 << NYW) / YAW_TURN;
  // speed scaling: x = 25*|speed| = 357*a + b, then b part by reciprocal of 714
  localparam int XW   = 20;
  localparam longint unsigned R1 = (64'd1 << XW) / 357;
  localparam int R1W  = 12;
  localparam int K2   = F + 10;
  localparam longint unsigned R2 = (64'd1 << K2) / 714;
  localparam int R2W  = F + 1;
  localparam int SW   = F + 2;
  localparam int PMW  = F + 14;
  localparam int MW   = F + 16;
  localparam int SQW  = F + 14;
  localparam int EW   = F + 16;
  localparam int OW   = F + 17;
  localparam int CW   = (F + 1 > 17) ? F + 1 : 17;
  localparam int PW   = 25 + CW;
  localparam int ACCW = F + 44;
  localparam int SH   = 16 + F;
  localparam int DW   = ACCW - SH;
  localparam int SPW  = F + 8;
  localparam longint unsigned SPIN_STEP = ((64'd3 << F) + 64'd50) / 64'd100;
  localparam longint unsigned SPIN_MAX  = 64'd240 << F;

  localparam logic [1:0] SPIN_UP   = 2'd1;
  localparam logic [1:0] SPIN_DOWN = 2'd2;

  typedef logic [F:0] rom_t [QTR + 1];

  // quarter-wave sine entry: Taylor series in Q30, rounded to F fraction bits
  function automatic logic [F:0] sin_entry(input int k);
    longint unsigned one, a, a2, t, s;
    one = 64'd1 << 30;
    a  = ((longint'(k) * 64'd1686629713) + (64'd1 << (T - 3))) >> (T - 2);
    a2 = (a * a) >> 30;
    t  = one;
    t  = one - ((a2 * t) >> 30) / 64'd156;
    t  = one - ((a2 * t) >> 30) / 64'd110;
    t  = one - ((a2 * t) >> 30) / 64'd72;
    t  = one - ((a2 * t) >> 30) / 64'd42;
    t  = one - ((a2 * t) >> 30) / 64'd20;
    t  = one - ((a2 * t) >> 30) / 64'd6;
    s  = (a * t) >> 30;
    return (F + 1)'((s + (64'd1 << (29 - F))) >> (30 - F));
  endfunction

  function automatic rom_t build_rom();
    rom_t r;
    for (int k = 0; k <= QTR; k++) begin
      r[k] = sin_entry(k);
    end
    return r;
  endfunction

  localparam rom_t SinRom = build_rom();

  function automatic logic signed [SW-1:0] sin_lut(input logic [T-1:0] idx);
    logic [1:0]   quad;
    logic [T-2:0] rix;
    logic [SW-1:0] v;
    quad = idx[T-1:T-2];
    rix  = quad[0] ? ((T-1)'(QTR) - (T-1)'(idx[T-3:0])) : (T-1)'(idx[T-3:0]);
    v    = SW'(SinRom[rix]);
    return quad[1] ? -$signed(v) : $signed(v);
  endfunction

  // configuration
  logic [23:0] gain_p_q, gain_i_q, gain_d_q;
  logic [13:0] out_lim_q;
  logic [14:0] int_lim_q;

  // latched word
  logic signed [11:0] ty_q, tx_q;
  logic [12:0]        yaw_q;
  logic [1:0]         cmd_q;
  logic signed [15:0] spd_q [NUM_WHEELS];

  // preparation
  logic [NYW+T-1:0]   yprod_q;
  logic [T-1:0]       p_q;
  logic signed [SW-1:0] s_q, c_q;
  logic signed [PMW-1:0] m1_q, m2_q;
  logic signed [PMW:0]   setx_q, sety_q;
  logic [XW+R1W-1:0]  aprod_q [NUM_WHEELS];
  logic [11:0]        a_q     [NUM_WHEELS];
  logic [K2-1:0]      n2_q    [NUM_WHEELS];
  logic [K2+R2W-1:0]  q2prod_q[NUM_WHEELS];
  logic signed [SQW-1:0] sq_q [NUM_WHEELS];
  logic signed [EW-1:0]  e_q  [NUM_WHEELS];

  // loop state
  logic [SPW-1:0]       spin_q;
  logic signed [EW-1:0] prev_q [NUM_WHEELS];
  logic signed [EW-1:0] sum_q  [NUM_WHEELS];
  logic signed [OW-1:0] de_q   [NUM_WHEELS];

  // PID multiply and accumulate
  logic signed [PW-1:0]   prod_q;
  logic                   pvalid_q, phi_q, pfirst_q, plast_q;
  logic [1:0]             pwheel_q;
  logic signed [ACCW-1:0] acc_q;
  logic signed [14:0]     res_q [NUM_WHEELS];
  logic signed [14:0]     drive_q [NUM_WHEELS];

  // combinational
  logic [NYW-1:0]       ny;
  logic [NYW+T-1:0]     yprod_d;
  logic [T-1:0]         yq0;
  logic [NYW-1:0]       ry;
  logic [T-1:0]         p_d;
  logic [16:0]          mag   [NUM_WHEELS];
  logic [XW-1:0]        xv    [NUM_WHEELS];
  logic [XW+R1W-1:0]    aprod_d [NUM_WHEELS];
  logic [11:0]          a0    [NUM_WHEELS];
  logic [XW-1:0]        b0    [NUM_WHEELS];
  logic [11:0]          a_d   [NUM_WHEELS];
  logic [K2-1:0]        n2_d  [NUM_WHEELS];
  logic [K2+R2W-1:0]    q2prod_d [NUM_WHEELS];
  logic [R2W-1:0]       q20   [NUM_WHEELS];
  logic [K2-1:0]        r2    [NUM_WHEELS];
  logic [SQW-1:0]       sqm   [NUM_WHEELS];
  logic signed [SQW-1:0] sq_d [NUM_WHEELS];
  logic signed [MW-1:0] mix   [NUM_WHEELS];
  logic signed [MW-1:0] mixb  [NUM_WHEELS];
  logic signed [15:0]   tgt   [NUM_WHEELS];
  logic signed [EW-1:0] e_d   [NUM_WHEELS];
  logic signed [OW-1:0] nsum  [NUM_WHEELS];
  logic signed [OW-1:0] ilim;
  logic signed [EW-1:0] sum_d [NUM_WHEELS];
  logic signed [OW-1:0] de_d  [NUM_WHEELS];
  logic [SPW:0]         spin_up;
  logic [SPW-1:0]       spin_d;
  logic signed [MW-1:0] wv;
  logic signed [OW-1:0] op;
  logic [23:0]          gain;
  logic signed [CW-1:0] chunk;
  logic signed [PW-1:0] prod_d;
  logic signed [ACCW-1:0] addend, acc_d, acc_b;
  logic signed [DW-1:0] rtr;
  logic signed [DW-1:0] olim;
  logic signed [14:0]   drv;

  always_comb begin
    // yaw to table index
    ny      = (NYW'(yaw_q) << T) + NYW'(YAW_HALF);
    yprod_d = (NYW+T)'(ny) * (NYW+T)'(RY);
    yq0     = yprod_q[NYW +: T];
    ry      = ny - NYW'(yq0) * NYW'(YAW_TURN);
    p_d     = yq0 + T'(ry >= NYW'(YAW_TURN)) + T'(QTR);

    wv   = MW'({1'b0, spin_q});
    ilim = OW'({1'b0, int_lim_q}) <<< F;

    for (int i = 0; i < NUM_WHEELS; i++) begin
      mag[i]     = spd_q[i][15] ? 17'(-(17'(spd_q[i]))) : 17'(spd_q[i]);
      xv[i]      = XW'(mag[i]) * XW'(25);
      aprod_d[i] = (XW+R1W)'(xv[i]) * (XW+R1W)'(R1);
      a0[i]      = aprod_q[i][XW +: 12];
      b0[i]      = xv[i] - XW'(a0[i]) * XW'(357);
      a_d[i]     = a0[i] + 12'(b0[i] >= XW'(357));
      n2_d[i]    = ((b0[i] >= XW'(357)) ? K2'(b0[i] - XW'(357)) : K2'(b0[i]))
                   << (F + 1);
      n2_d[i]    = n2_d[i] + K2'(357);
      q2prod_d[i] = (K2+R2W)'(n2_q[i]) * (K2+R2W)'(R2);
      q20[i]     = q2prod_q[i][K2 +: R2W];
      r2[i]      = n2_q[i] - K2'(q20[i]) * K2'(714);
      sqm[i]     = (SQW'(a_q[i]) << F) + SQW'(q20[i]) + SQW'(r2[i] >= K2'(714));
      sq_d[i]    = spd_q[i][15] ? -$signed(sqm[i]) : $signed(sqm[i]);
    end

    // mecanum mixing
    mix[0] = MW'(sety_q) + MW'(setx_q) + wv;
    mix[1] = MW'(sety_q) - MW'(setx_q) + wv;
    mix[2] = wv - MW'(sety_q) - MW'(setx_q);
    mix[3] = wv - MW'(sety_q) + MW'(setx_q);
    for (int i = 0; i < NUM_WHEELS; i++) begin
      // truncate toward zero
      mixb[i]  = mix[i] + (mix[i][MW-1] ? MW'((64'd1 << F) - 64'd1) : MW'(0));
      tgt[i]   = $signed(mixb[i][MW-1:F]);
      e_d[i]   = (EW'(tgt[i]) <<< F) - EW'(sq_q[i]);
      nsum[i]  = OW'(sum_q[i]) + OW'(e_q[i]);
      if (nsum[i] > ilim) begin
        sum_d[i] = EW'(ilim);
      end else if (nsum[i] < -ilim) begin
        sum_d[i] = EW'(-ilim);
      end else begin
        sum_d[i] = EW'(nsum[i]);
      end
      de_d[i] = OW'(e_q[i]) - OW'(prev_q[i]);
    end

    // spin ramp
    spin_up = (SPW+1)'(spin_q) + (SPW+1)'(SPIN_STEP);
    case (cmd_q)
      SPIN_UP: begin
        spin_d = (spin_up > (SPW+1)'(SPIN_MAX)) ? SPW'(SPIN_MAX) : SPW'(spin_up);
      end
      SPIN_DOWN: begin
        spin_d = (spin_q > SPW'(SPIN_STEP)) ? spin_q - SPW'(SPIN_STEP) : '0;
      end
      default: begin
        spin_d = spin_q;
      end
    endcase

    // PID operand and gain
    case (cmd_i.pid_term)
      TERM_P: begin
        op   = OW'(e_q[cmd_i.pid_wheel]);
        gain = gain_p_q;
      end
      TERM_I: begin
        op   = OW'(sum_q[cmd_i.pid_wheel]);
        gain = gain_i_q;
      end
      default: begin
        op   = de_q[cmd_i.pid_wheel];
        gain = gain_d_q;
      end
    endcase
    chunk  = cmd_i.pid_hi ? CW'(op >>> 16) : CW'({1'b0, op[15:0]});
    prod_d = $signed({1'b0, gain}) * chunk;

    addend = phi_q ? (ACCW'(prod_q) <<< 16) : ACCW'(prod_q);
    acc_d  = pfirst_q ? addend : acc_q + addend;
    acc_b  = acc_d + (acc_d[ACCW-1] ? ACCW'((64'd1 << SH) - 64'd1) : ACCW'(0));
    rtr    = $signed(acc_b[ACCW-1:SH]);
    olim   = DW'({1'b0, out_lim_q});
    if (rtr > olim) begin
      drv = 15'(olim);
    end else if (rtr < -olim) begin
      drv = 15'(-olim);
    end else begin
      drv = 15'(rtr);
    end
  end

  // configuration and loop state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q  <= '0;
      gain_i_q  <= '0;
      gain_d_q  <= '0;
      out_lim_q <= 14'd6500;
      int_lim_q <= 15'd9450;
      spin_q    <= '0;
      pvalid_q  <= 1'b0;
      for (int i = 0; i < NUM_WHEELS; i++) begin
        prev_q[i] <= '0;
        sum_q[i]  <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_GAIN_P:         gain_p_q  <= cfg_data_i;
          CFG_GAIN_I:         gain_i_q  <= cfg_data_i;
          CFG_GAIN_D:         gain_d_q  <= cfg_data_i;
          CFG_OUTPUT_LIMIT:   out_lim_q <= cfg_data_i[13:0];
          CFG_INTEGRAL_LIMIT: int_lim_q <= cfg_data_i[14:0];
          default: ;
        endcase
      end
      if (cmd_i.prep_en && cmd_i.prep_step == STEP_MUL_A) begin
        spin_q <= spin_d;
      end
      if (cmd_i.prep_en && cmd_i.prep_step == STEP_COMMIT) begin
        for (int i = 0; i < NUM_WHEELS; i++) begin
          prev_q[i] <= e_q[i];
          sum_q[i]  <= sum_d[i];
        end
      end
      pvalid_q <= cmd_i.pid_en;
    end
  end

  // payload, preparation, accumulate and output registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ty_q  <= target_y_i;
      tx_q  <= target_x_i;
      yaw_q <= yaw_angle_i;
      cmd_q <= spin_cmd_i;
      spd_q[0] <= wheel1_speed_i;
      spd_q[1] <= wheel2_speed_i;
      spd_q[2] <= wheel3_speed_i;
      spd_q[3] <= wheel4_speed_i;
    end
    if (cmd_i.prep_en) begin
      case (cmd_i.prep_step)
        STEP_RECIP: begin
          yprod_q <= yprod_d;
          for (int i = 0; i < NUM_WHEELS; i++) aprod_q[i] <= aprod_d[i];
        end
        STEP_CORR: begin
          p_q <= p_d;
          for (int i = 0; i < NUM_WHEELS; i++) begin
            a_q[i]  <= a_d[i];
            n2_q[i] <= n2_d[i];
          end
        end
        STEP_ROM: begin
          s_q <= sin_lut(p_q);
          c_q <= sin_lut(p_q + T'(QTR));
          for (int i = 0; i < NUM_WHEELS; i++) q2prod_q[i] <= q2prod_d[i];
        end
        STEP_MUL_A: begin
          m1_q <= s_q * PMW'(ty_q);
          m2_q <= c_q * PMW'(tx_q);
          for (int i = 0; i < NUM_WHEELS; i++) sq_q[i] <= sq_d[i];
        end
        STEP_MUL_B: begin
          setx_q <= (PMW+1)'(m1_q) - (PMW+1)'(m2_q);
          m1_q   <= s_q * PMW'(tx_q);
          m2_q   <= c_q * PMW'(ty_q);
        end
        STEP_MIX: begin
          sety_q <= (PMW+1)'(m1_q) + (PMW+1)'(m2_q);
        end
        STEP_ERR: begin
          for (int i = 0; i < NUM_WHEELS; i++) e_q[i] <= e_d[i];
        end
        STEP_COMMIT: begin
          for (int i = 0; i < NUM_WHEELS; i++) de_q[i] <= de_d[i];
        end
        default: ;
      endcase
    end
    if (cmd_i.pid_en) begin
      prod_q   <= prod_d;
      phi_q    <= cmd_i.pid_hi;
      pwheel_q <= cmd_i.pid_wheel;
      pfirst_q <= (cmd_i.pid_term == TERM_P) && !cmd_i.pid_hi;
      plast_q  <= (cmd_i.pid_term == TERM_D) && cmd_i.pid_hi;
    end
    if (pvalid_q) begin
      acc_q <= acc_d;
      if (plast_q) begin
        res_q[pwheel_q] <= drv;
      end
    end
    if (cmd_i.out_load) begin
      for (int i = 0; i < NUM_WHEELS; i++) drive_q[i] <= res_q[i];
    end
  end

  assign wheel1_drive_o = drive_q[0];
  assign wheel2_drive_o = drive_q[1];
  assign wheel3_drive_o = drive_q[2];
  assign wheel4_drive_o = drive_q[3];

endmodule
